// ===== rtl/decimal_text_to_fixed_point_defines.svh =====
// Assertion macros for the decimal text to fixed point block.
// Used by the port checker; no other dependencies.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH

// same-cycle implication
`define DTFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtfp check failed");

// next-cycle implication
`define DTFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtfp check failed");

`endif

// ===== rtl/dtfp_pkg.sv =====
// Package for the decimal text to fixed point block.
// Character codes, parser phases, default sizes, the power-of-ten table
// and the reciprocal used to turn kept fraction digits into binary.
package dtfp_pkg;

  localparam int FRAC_BITS_DEF       = 32;
  localparam int INT_BITS_DEF        = 31;
  localparam int MAX_FRAC_DIGITS_DEF = 9;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 64;
  localparam int FRAC_W  = 30;  // holds up to nine decimal digits
  localparam int DIG_W   = 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam int                TEN      = 10;

  // fraction digits are scaled up to nine before conversion
  localparam int FRAC_FULL_DIGITS = 9;
  localparam int FRAC_BITS_FULL   = 32;

  // ceil(2^83 / 10^9): (f * RECIP) >> RECIP_SHIFT == floor(f * 2^32 / 10^9) for f < 10^9
  localparam int                 RECIP_W     = 54;
  localparam int                 RECIP_SHIFT = 51;
  localparam int                 RECIP_SPLIT = 27;
  localparam logic [RECIP_W-1:0] RECIP       = 54'd9671406556917034;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_INT    = 2'd1,
    PH_FRAC   = 2'd2,
    PH_FROZEN = 2'd3
  } phase_t;

  // 10^d; counts above nine read as 10^9
  function automatic logic [FRAC_W-1:0] pow10(input logic [DIG_W-1:0] d);
    logic [FRAC_W-1:0] p;
    case (d)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/decimal_text_to_fixed_point.sv =====
// Decimal text to signed fixed point: character parser, fraction conversion pipeline,
// output register with skid stage. Depends on dtfp_pkg.
//
//  channel | dir | tdata              | tuser      | tlast
//  s_*     | in  | [7:0] char_code    | -          | last character of string
//  m_*     | out | [63:0] value       | saturated  | -
//
// One character is taken per cycle while s_tready is high. A string end's result
// passes the scale of the fraction to nine digits, a split multiply by the
// reciprocal of 10^9, the partial-product add, then a negate stage.
// Reset (rst, synchronous) clears the parser and all valid flags.
// A result that waits on m_tready moves into a skid register; s_tready drops
// and the pipeline holds only while that skid register is full.
module decimal_text_to_fixed_point
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int INT_BITS        = INT_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] char_code
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VALUE_W-1:0] m_tdata,   // [63:0] value
  output logic               m_tuser    // [0] saturated
);

  localparam int PROD_W = INT_BITS + 4;
  localparam int PIPE_N = 4;
  localparam int PP_W   = FRAC_W + RECIP_SPLIT;
  localparam int Q_LSB  = RECIP_SHIFT - RECIP_SPLIT;
  localparam logic [INT_BITS-1:0] INT_LIMIT = {INT_BITS{1'b1}};

  typedef struct packed {
    logic [FRAC_W-1:0]    frac;
    logic [DIG_W-1:0]     dig;
    logic [INT_BITS-1:0]  ipart;
    logic                 neg;
    logic                 sat;
  } snap_t;

  typedef struct packed {
    logic [FRAC_W-1:0]    frac9;
    logic [INT_BITS-1:0]  ipart;
    logic                 neg;
    logic                 sat;
  } scaled_t;

  typedef struct packed {
    logic [PP_W-1:0]      p_hi;
    logic [PP_W-1:0]      p_lo;
    logic [INT_BITS-1:0]  ipart;
    logic                 neg;
    logic                 sat;
  } prod_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   mag;
    logic                 neg;
    logic                 sat;
  } mag_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               sat;
  } result_t;

  // parser state
  phase_t              phase, phase_next;
  logic                negative, negative_next;
  logic [INT_BITS-1:0] int_accum, int_accum_next;
  logic [FRAC_W-1:0]   frac_accum, frac_accum_next;
  logic [DIG_W-1:0]    frac_digits, frac_digits_next;
  logic                overflow_seen, overflow_seen_next;

  // values after the current character
  phase_t              ph_t;
  logic                neg_t, sat_t;
  logic [INT_BITS-1:0] int_t;
  logic [FRAC_W-1:0]   frac_t;
  logic [DIG_W-1:0]    fd_t;

  logic                accept, end_item, is_nul, is_digit, is_blank;
  logic [DIG_W-1:0]    dig_val;
  logic [PROD_W-1:0]   int_prod;
  logic                int_over;
  logic [FRAC_W+3:0]   frac_prod;

  logic                      enable;
  logic [PIPE_N-1:0]         sv;
  snap_t                     st_in, st0;
  scaled_t                   st1;
  prod_t                     st2;
  mag_t                      st3;
  logic [2*FRAC_W-1:0]       scale_prod;
  logic [PP_W:0]             upper;
  logic [FRAC_BITS_FULL-1:0] q_full;

  result_t             res, out_reg, skid;
  logic                res_v, out_valid, skid_valid, out_free;

  assign enable   = !skid_valid;
  assign s_tready = enable;
  assign accept   = s_tvalid && s_tready;

  assign is_nul   = (s_tdata == CH_NUL);
  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign is_blank = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR));
  assign dig_val  = DIG_W'(s_tdata - CH_ZERO);
  assign end_item = is_nul || s_tlast;

  assign int_prod  = PROD_W'(int_accum) * PROD_W'(TEN) + PROD_W'(dig_val);
  assign int_over  = int_prod > PROD_W'(INT_LIMIT);
  assign frac_prod = (FRAC_W+4)'(frac_accum) * (FRAC_W+4)'(TEN) + (FRAC_W+4)'(dig_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      negative      <= 1'b0;
      int_accum     <= '0;
      frac_accum    <= '0;
      frac_digits   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      phase         <= phase_next;
      negative      <= negative_next;
      int_accum     <= int_accum_next;
      frac_accum    <= frac_accum_next;
      frac_digits   <= frac_digits_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_comb begin
    ph_t   = phase;
    neg_t  = negative;
    int_t  = int_accum;
    sat_t  = overflow_seen;
    frac_t = frac_accum;
    fd_t   = frac_digits;
    if (!is_nul) begin
      case (phase)
        PH_LEAD: begin
          if (is_blank) begin
            ph_t = PH_LEAD;
          end else if (s_tdata == CH_MINUS) begin
            neg_t = 1'b1;
            ph_t  = PH_INT;
          end else if (s_tdata == CH_PLUS) begin
            ph_t = PH_INT;
          end else if (is_digit) begin
            int_t = int_over ? INT_LIMIT : int_prod[INT_BITS-1:0];
            sat_t = overflow_seen || int_over;
            ph_t  = PH_INT;
          end else if (s_tdata == CH_DOT) begin
            ph_t = PH_FRAC;
          end else begin
            ph_t = PH_FROZEN;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            int_t = int_over ? INT_LIMIT : int_prod[INT_BITS-1:0];
            sat_t = overflow_seen || int_over;
          end else if (s_tdata == CH_DOT) begin
            ph_t = PH_FRAC;
          end else begin
            ph_t = PH_FROZEN;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (frac_digits < DIG_W'(MAX_FRAC_DIGITS)) begin
              frac_t = frac_prod[FRAC_W-1:0];
              fd_t   = frac_digits + 1'b1;
            end
          end else begin
            ph_t = PH_FROZEN;
          end
        end
        default: begin
          ph_t = PH_FROZEN;
        end
      endcase
    end

    phase_next         = phase;
    negative_next      = negative;
    int_accum_next     = int_accum;
    frac_accum_next    = frac_accum;
    frac_digits_next   = frac_digits;
    overflow_seen_next = overflow_seen;
    if (accept) begin
      if (end_item) begin
        phase_next         = PH_LEAD;
        negative_next      = 1'b0;
        int_accum_next     = '0;
        frac_accum_next    = '0;
        frac_digits_next   = '0;
        overflow_seen_next = 1'b0;
      end else begin
        phase_next         = ph_t;
        negative_next      = neg_t;
        int_accum_next     = int_t;
        frac_accum_next    = frac_t;
        frac_digits_next   = fd_t;
        overflow_seen_next = sat_t;
      end
    end
  end

  always_comb begin
    st_in.frac  = frac_t;
    st_in.dig   = fd_t;
    st_in.ipart = int_t;
    st_in.neg   = neg_t;
    st_in.sat   = sat_t;
  end

  // frac / 10^dig == frac9 / 10^9, then frac9 * 2^32 / 10^9 by reciprocal
  assign scale_prod = (2*FRAC_W)'(st0.frac) *
                      (2*FRAC_W)'(pow10(DIG_W'(FRAC_FULL_DIGITS) - st0.dig));
  assign upper      = (PP_W+1)'(st2.p_hi) + (PP_W+1)'(st2.p_lo[PP_W-1:RECIP_SPLIT]);
  assign q_full     = upper[Q_LSB +: FRAC_BITS_FULL];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (enable) begin
      sv <= {sv[PIPE_N-2:0], accept && end_item};
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      st0       <= st_in;
      st1.frac9 <= scale_prod[FRAC_W-1:0];
      st1.ipart <= st0.ipart;
      st1.neg   <= st0.neg;
      st1.sat   <= st0.sat;
      st2.p_hi  <= PP_W'(st1.frac9) * PP_W'(RECIP[RECIP_W-1:RECIP_SPLIT]);
      st2.p_lo  <= PP_W'(st1.frac9) * PP_W'(RECIP[RECIP_SPLIT-1:0]);
      st2.ipart <= st1.ipart;
      st2.neg   <= st1.neg;
      st2.sat   <= st1.sat;
      st3.mag   <= VALUE_W'({st2.ipart, q_full[FRAC_BITS_FULL-1 -: FRAC_BITS]});
      st3.neg   <= st2.neg;
      st3.sat   <= st2.sat;
    end
  end

  // sign of the finished value
  always_comb begin
    res.value = st3.neg ? (VALUE_W'(0) - st3.mag) : st3.mag;
    res.sat   = st3.sat;
  end

  assign res_v    = enable && sv[PIPE_N-1];
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        out_reg    <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_v) begin
      if (out_free) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg.value;
  assign m_tuser  = out_reg.sat;

endmodule

// ===== rtl/dtfp_checker.sv =====
// Port checker for decimal_text_to_fixed_point, with its bind statement.
// Depends on dtfp_pkg and decimal_text_to_fixed_point_defines.svh.
`include "decimal_text_to_fixed_point_defines.svh"

module dtfp_checker
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int INT_BITS  = INT_BITS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [VALUE_W-1:0] m_tdata,
  input logic               m_tuser
);

  logic sat_pos_ok;

  assign sat_pos_ok = (m_tdata[FRAC_BITS +: INT_BITS] == {INT_BITS{1'b1}});

  // a held result stays valid and unchanged
  `DTFP_ASSERT_NEXT(a_out_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `DTFP_ASSERT_NEXT(a_out_hold_data, clk, rst, m_tvalid && !m_tready,
                    $stable(m_tdata) && $stable(m_tuser))
  // with no result pending the skid stage is empty, so input is open
  `DTFP_ASSERT_IMPLY(a_ready_when_idle, clk, rst, !m_tvalid, s_tready)
  // a clamped positive result carries an all-ones integer part
  `DTFP_ASSERT_IMPLY(a_sat_value, clk, rst, m_tvalid && m_tuser && !m_tdata[VALUE_W-1],
                     sat_pos_ok)

endmodule

bind decimal_text_to_fixed_point dtfp_checker #(
  .FRAC_BITS (FRAC_BITS),
  .INT_BITS  (INT_BITS)
) u_dtfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for decimal_text_to_fixed_point: streams text one character
// per transfer, predicts each fixed-point result and checks it field by field.
// Depends on dtfp_pkg and the decimal_text_to_fixed_point RTL only.
module testbench;
  import dtfp_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int TEXT_BUDGET    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = FRAC_BITS_DEF + 8;
  localparam logic [63:0] INT_LIMIT = (64'd1 << INT_BITS_DEF) - 64'd1;

  typedef logic [CHAR_W-1:0] text_q_t[$];

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               saturated;
  } fixed_result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_QUARTER,
    RDY_LONG_STALL
  } ready_style_t;

  typedef enum logic [2:0] {
    STYLE_NOISE,
    STYLE_NEAR_LIMIT,
    STYLE_LONG_INT,
    STYLE_LONG_FRAC,
    STYLE_PLAIN
  } text_style_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [CHAR_W-1:0]  s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [VALUE_W-1:0] m_tdata;
  logic               m_tuser;

  decimal_text_to_fixed_point dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // parser mirror
  phase_t                  parse_phase = PH_LEAD;
  logic                    neg = 1'b0;
  logic [INT_BITS_DEF-1:0] int_acc = '0;
  logic [FRAC_W-1:0]       frac_acc = '0;
  logic [DIG_W-1:0]        frac_cnt = '0;
  logic                    ovf = 1'b0;

  fixed_result_t pending_results[$];

  int errors = 0;
  int chars_sent = 0;
  int results_checked = 0;
  int saturated_count = 0;
  int negative_count = 0;
  int frozen_count = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  ready_style_t ready_style = RDY_ALWAYS;
  int           ready_span = 0;
  logic [7:0]   ready_tick = '0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic void clear_parser();
    parse_phase = PH_LEAD;
    neg = 1'b0;
    int_acc = '0;
    frac_acc = '0;
    frac_cnt = '0;
    ovf = 1'b0;
  endfunction

  function automatic void push_int_digit(input logic [3:0] dig);
    logic [63:0] next;
    next = 64'(int_acc) * 64'(TEN) + 64'(dig);
    if (next > INT_LIMIT) begin
      int_acc = INT_LIMIT[INT_BITS_DEF-1:0];
      ovf = 1'b1;
    end else begin
      int_acc = next[INT_BITS_DEF-1:0];
    end
  endfunction

  function automatic void parse_char(input logic [CHAR_W-1:0] code);
    logic       is_digit;
    logic       is_blank;
    logic [3:0] dig;
    is_digit = (code >= CH_ZERO) && (code <= CH_NINE);
    is_blank = (code == CH_SPACE) || ((code >= CH_TAB) && (code <= CH_CR));
    dig = 4'(code - CH_ZERO);
    case (parse_phase)
      PH_LEAD: begin
        if (is_blank) begin
        end else if (code == CH_MINUS) begin
          neg = 1'b1;
          parse_phase = PH_INT;
        end else if (code == CH_PLUS) begin
          parse_phase = PH_INT;
        end else if (is_digit) begin
          push_int_digit(dig);
          parse_phase = PH_INT;
        end else if (code == CH_DOT) begin
          parse_phase = PH_FRAC;
        end else begin
          parse_phase = PH_FROZEN;
        end
      end
      PH_INT: begin
        if (is_digit) push_int_digit(dig);
        else if (code == CH_DOT) parse_phase = PH_FRAC;
        else parse_phase = PH_FROZEN;
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (frac_cnt < DIG_W'(MAX_FRAC_DIGITS_DEF)) begin
            frac_acc = FRAC_W'(64'(frac_acc) * 64'(TEN) + 64'(dig));
            frac_cnt = frac_cnt + 1'b1;
          end
        end else begin
          parse_phase = PH_FROZEN;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // one accepted character; a string end queues the expected fixed-point value
  function automatic void predict_char(input logic [CHAR_W-1:0] code, input logic fin);
    logic [63:0]   scale;
    logic [63:0]   frac_part;
    logic [63:0]   mag;
    fixed_result_t want;
    if (code != CH_NUL) parse_char(code);
    if (code != CH_NUL && !fin) return;
    scale = 64'd1;
    for (int k = 0; k < int'(frac_cnt); k++) scale = scale * 64'(TEN);
    frac_part = (64'(frac_acc) << FRAC_BITS_DEF) / scale;
    mag = (64'(int_acc) << FRAC_BITS_DEF) + frac_part;
    want.value = neg ? (64'd0 - mag) : mag;
    want.saturated = ovf;
    pending_results.push_back(want);
    if (ovf) saturated_count++;
    if (neg) negative_count++;
    if (parse_phase == PH_FROZEN) frozen_count++;
    clear_parser();
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic fin);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_char(code, fin);
    chars_sent++;
  endtask

  task automatic send_bytes(input text_q_t txt, input bit end_on_last);
    for (int i = 0; i < txt.size(); i++) begin
      send_char(txt[i], end_on_last && (i == txt.size() - 1));
    end
    if (!end_on_last) send_char(CH_NUL, 1'b0);
  endtask

  task automatic send_text(input string txt, input bit end_on_last);
    text_q_t q;
    for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
    send_bytes(q, end_on_last);
  endtask

  task automatic test_string_ends();
    send_char(CH_NUL, 1'b0);
    send_text("-0", 1'b1);
    send_text("\t+.5", 1'b0);
  endtask

  task automatic test_freeze_rules();
    send_text("\n\v\f\015- 3", 1'b1);
    send_text("7-1", 1'b1);
    send_text("1.2.\377", 1'b1);
    send_text("+-3", 1'b1);
  endtask

  task automatic send_random_text();
    text_q_t     txt;
    text_style_t style;
    int          pick;
    string       near_top;
    pick = $urandom_range(0, 9);
    style = (pick == 0) ? STYLE_NOISE :
            (pick == 1) ? STYLE_NEAR_LIMIT :
            (pick == 2) ? STYLE_LONG_INT :
            (pick == 3) ? STYLE_LONG_FRAC : STYLE_PLAIN;
    if (style == STYLE_NOISE) begin
      repeat ($urandom_range(1, 8)) begin
        send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      txt.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4)));
    end
    pick = $urandom_range(0, 2);
    if (pick == 1) txt.push_back(CH_MINUS);
    else if (pick == 2) txt.push_back(CH_PLUS);
    if (style == STYLE_NEAR_LIMIT) begin
      near_top = "214748364";
      for (int i = 0; i < near_top.len(); i++) txt.push_back(near_top[i]);
      txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end else begin
      repeat ((style == STYLE_LONG_INT) ? $urandom_range(10, 12) : $urandom_range(0, 5)) begin
        txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
    end
    if (style == STYLE_LONG_FRAC || $urandom_range(0, 9) < 7) begin
      txt.push_back(CH_DOT);
      repeat ((style == STYLE_LONG_FRAC) ? $urandom_range(9, 12) : $urandom_range(0, 4)) begin
        txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(1, 255)));
    end
    if (txt.size() == 0) txt.push_back(CH_ZERO);
    send_bytes(txt, ($urandom_range(0, 1) == 1));
  endtask

  task automatic test_random_text();
    while (chars_sent < TEXT_BUDGET) send_random_text();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_string_ends();
    test_freeze_rules();
    test_random_text();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d characters and checked %0d values", chars_sent, results_checked);
    $display("Strings ending saturated %0d, negative %0d, frozen early %0d",
             saturated_count, negative_count, frozen_count);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_style <= ready_style_t'($urandom_range(0, 3));
      ready_span  <= $urandom_range(16, 96);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_style)
      RDY_ALWAYS:  m_tready <= 1'b1;
      RDY_COIN:    m_tready <= 1'($urandom_range(0, 1));
      RDY_QUARTER: m_tready <= (ready_tick[1:0] == 2'd0);
      default:     m_tready <= (ready_tick[4:0] >= 5'd20);
    endcase
    ready_tick <= ready_tick + 1'b1;
  end

  always @(posedge clk) begin
    fixed_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: value %h saturated %b", m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.value) begin
          $error("value: expected %h, actual %h", want.value, m_tdata);
          errors++;
        end
        if (m_tuser !== want.saturated) begin
          $error("saturated: expected %b, actual %b", want.saturated, m_tuser);
          errors++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dtfp_pkg.sv
rtl/decimal_text_to_fixed_point.sv
rtl/dtfp_checker.sv
sim/testbench.sv
